### hdl/ytri_pkg.sv
package ytri_pkg;

  // Tableau geometry and value width.
  localparam int MAX_LEN    = 32;
  localparam int VALUE_BITS = 16;

  // Derived widths.
  localparam int VAL_W  = VALUE_BITS;
  localparam int ROW_W  = $clog2(MAX_LEN);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int DEPTH  = MAX_LEN * MAX_LEN;
  localparam int ADDR_W = $clog2(DEPTH);

  // Fixed field widths of the result beat.
  localparam int POS_W = 5;

  typedef struct packed {
    logic [15:0] value;
    logic        start_req;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
    logic             boring;
    logic             overflow;
  } result_t;

  // Flat address of a tableau cell, rows laid out one after another.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [LEN_W-1:0] c);
    cell_addr = ADDR_W'(r) * ADDR_W'(MAX_LEN) + ADDR_W'(c);
  endfunction

endpackage

### hdl/ytri_ram.sv
module ytri_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/young_tableau_row_insert.sv
// Channel  | Ports                    | Handshake
// ---------+--------------------------+----------------------------------------------
// item     | start, busy, item        | beat taken at a clock edge with start & !busy
// result   | done, result             | beat shown for one cycle while done is high
//
// One item is first taken in; then for every row it visits, the row length is
// fetched, each tableau entry compared takes a memory read and then a compare, a scan
// that reaches the left end goes straight from its read step to placement, and x is
// placed or bumped. A new row is opened in the row-length step itself. The single-
// port-read tableau memory and the one compare unit set this order of steps.
// An item refused for lack of room gives its result in the cycle after it is taken.
// Reset clears the row lengths, counters and boring flag at once; the tableau memory
// is not cleared, since no cell is read before it is written.
// The receiver cannot stall: each result beat is on the ports for one cycle only.
module young_tableau_row_insert (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ytri_pkg::item_t item,
  output logic            done,
  output ytri_pkg::result_t result
);

  import ytri_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW,
    S_SCAN,
    S_CMP,
    S_PLACE
  } state_t;

  // The enum above needs three bits for five states.
  state_t state;

  // Working registers of the current item.
  logic [VAL_W-1:0] x;           // value being inserted into the current row
  logic [VAL_W-1:0] cand;        // last entry found greater than x
  logic [ROW_W-1:0] i;           // current row
  logic [LEN_W-1:0] j;           // scan position within the row
  logic [LEN_W-1:0] len;         // length of the current row
  logic             have_first;  // first bump column recorded
  logic             mismatch;    // a later bump left that column
  logic [LEN_W-1:0] first_col;

  // Tableau bookkeeping.
  logic [LEN_W-1:0] row_lengths [MAX_LEN];
  logic [LEN_W-1:0] row_count;
  logic [LEN_W-1:0] item_count;
  logic             boring_flag;

  // Tableau memory ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  logic new_row;    // current row lies below the last open row
  logic hit_zero;   // final placement at column zero repeats the first bump column
  logic hit_j;      // placement or bump at column j repeats the first bump column

  assign busy     = (state != S_IDLE);
  assign new_row  = (LEN_W'(i) >= row_count);
  assign hit_zero = have_first && !mismatch && (first_col == '0);
  assign hit_j    = have_first && !mismatch && (first_col == j);

  // A new row is written at column zero; a placement or bump writes at column j,
  // except for an append to a row that is already full.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cell_addr(i, j);
    ram_raddr = cell_addr(i, j - LEN_W'(1));
    if (state == S_ROW && new_row) begin
      ram_we    = 1'b1;
      ram_waddr = cell_addr(i, '0);
    end else if (state == S_PLACE) begin
      ram_we = (j != len) || (len < LEN_W'(MAX_LEN));
    end
  end

  ytri_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_tableau (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(x),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      row_count   <= '0;
      item_count  <= '0;
      boring_flag <= 1'b0;
      for (int k = 0; k < MAX_LEN; k++) begin
        row_lengths[k] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            x          <= item.value[VAL_W-1:0];
            i          <= '0;
            have_first <= 1'b0;
            mismatch   <= 1'b0;
            first_col  <= '0;
            if (item.start_req) begin
              // A start request empties the tableau before this value goes in.
              for (int k = 0; k < MAX_LEN; k++) begin
                row_lengths[k] <= '0;
              end
              row_count   <= '0;
              item_count  <= LEN_W'(1);
              boring_flag <= 1'b0;
              state       <= S_ROW;
            end else if (item_count >= LEN_W'(MAX_LEN)) begin
              // The tableau is full: the value is dropped and the state kept.
              done            <= 1'b1;
              result.row      <= '0;
              result.column   <= '0;
              result.boring   <= boring_flag;
              result.overflow <= 1'b1;
            end else begin
              item_count <= item_count + LEN_W'(1);
              state      <= S_ROW;
            end
          end
        end

        S_ROW: begin
          if (new_row) begin
            // Open a new row that holds only x.
            row_lengths[i]  <= LEN_W'(1);
            row_count       <= LEN_W'(i) + LEN_W'(1);
            boring_flag     <= boring_flag | hit_zero;
            done            <= 1'b1;
            result.row      <= POS_W'(i);
            result.column   <= '0;
            result.boring   <= boring_flag | hit_zero;
            result.overflow <= 1'b0;
            state           <= S_IDLE;
          end else begin
            len   <= row_lengths[i];
            j     <= row_lengths[i];
            state <= S_SCAN;
          end
        end

        S_SCAN: begin
          // The read of the entry left of j is issued in this cycle.
          if (j == '0) begin
            state <= S_PLACE;
          end else begin
            state <= S_CMP;
          end
        end

        S_CMP: begin
          if (x < ram_rdata) begin
            cand  <= ram_rdata;
            j     <= j - LEN_W'(1);
            state <= S_SCAN;
          end else begin
            state <= S_PLACE;
          end
        end

        S_PLACE: begin
          if (j == len) begin
            // Nothing greater in this row: x goes at its end.
            if (len < LEN_W'(MAX_LEN)) begin
              row_lengths[i] <= len + LEN_W'(1);
            end
            boring_flag     <= boring_flag | hit_j;
            done            <= 1'b1;
            result.row      <= POS_W'(i);
            result.column   <= POS_W'(j);
            result.boring   <= boring_flag | hit_j;
            result.overflow <= 1'b0;
            state           <= S_IDLE;
          end else begin
            // x took the place of cand, which moves down one row.
            if (!have_first) begin
              have_first <= 1'b1;
              first_col  <= j;
            end else if (hit_j) begin
              boring_flag <= 1'b1;
            end else begin
              mismatch <= 1'b1;
            end
            x     <= cand;
            i     <= i + ROW_W'(1);
            state <= S_ROW;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result beat always ends the work on an item, so the block is ready again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while still busy");

  // Every row holds at least one value, so rows never outnumber inserted values.
  a_rows_bounded: assert property (@(posedge clk) disable iff (rst)
    row_count <= item_count)
    else $error("more rows than inserted values");

  a_items_bounded: assert property (@(posedge clk) disable iff (rst)
    item_count <= LEN_W'(MAX_LEN))
    else $error("item count beyond capacity");

  // A compare only follows a read of a real entry left of the scan position.
  a_cmp_in_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (j != '0) && (j <= len))
    else $error("compare outside the row");

  // A refused item reports the top left corner.
  a_overflow_pos: assert property (@(posedge clk) disable iff (rst)
    (done && result.overflow) |-> (result.row == '0) && (result.column == '0))
    else $error("overflow result with a position");

endmodule
